/* hw/rtl/cwf_pkg.sv */
// Shared constants for the 3x3 window filter.
`default_nettype none
package cwf_pkg;
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int POS_W          = 20;
   localparam int CFG_AW         = 5;
   localparam int CFG_DW         = 32;
   localparam logic [7:0] PIX_MAX = 8'd255;

   localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
   localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
   localparam logic [2:0] REG_KERNEL_TOP   = 3'd2;
   localparam logic [2:0] REG_KERNEL_MID   = 3'd3;
   localparam logic [2:0] REG_KERNEL_BOT   = 3'd4;
   localparam logic [2:0] REG_DIVISOR      = 3'd5;
   localparam logic [2:0] REG_BORDER_MODE  = 3'd6;

   localparam logic [10:0] RST_FRAME_WIDTH  = 11'd640;
   localparam logic [10:0] RST_FRAME_HEIGHT = 11'd480;
   localparam logic [23:0] RST_KERNEL_ROW   = 24'h010101;
   localparam logic [11:0] RST_DIVISOR      = 12'd9;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_DRAIN = 1'b1;
endpackage
`default_nettype wire

/* hw/rtl/cwf_ram.sv */
// Generic single-port RAM with a registered read.
`default_nettype none
module cwf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     rd_en,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[addr];
      end
   end
endmodule
`default_nettype wire

/* hw/rtl/conv3x3_window_filter.sv */
// Usage notes: 3x3 convolution filter over a raster-order 8-bit pixel stream.
// The req channel carries one beat per pixel (req_kind = pixel) or drain tick
// (req_kind = drain); the rsp channel carries filtered pixels, with
// rsp_frame_last set on the final pixel of a frame. Both channels move a beat
// when valid is high and stall is low. The result for raster position p
// is produced by the beat p + width + 1 of the frame; width + 1 drain ticks
// flush the tail. A drain tick at the very start of a frame is dropped.
// One beat is handled at a time. A beat that makes a result passes through
// the shared 20-step restoring divider (position split), the 9-step
// multiply-accumulate and the divider again (normalization); in pass-through
// border mode a border position skips the last two. Its result shows on rsp
// when the next beat can be taken. A result waits in an output register, so
// a receiver stall only holds req_stall high once a further result is ready
// while that register is still full.
// The two line stores share one 16-bit RAM, read and written back per beat.
// Synchronous reset clears the counters and window, empties the output
// register and restores the configuration defaults; the line RAM is not
// cleared and needs no time after reset. The user is to write the APB-style
// register port only while the stream is idle; the block does not enforce it.
`default_nettype none
module conv3x3_window_filter
   import cwf_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_kind,
   input  wire logic [7:0]        req_pixel_in,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic      [7:0]        rsp_pixel_out,
   output logic                   rsp_frame_last,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [CFG_AW-1:0] paddr,
   input  wire logic [CFG_DW-1:0] pwdata,
   output logic      [CFG_DW-1:0] prdata,
   output logic                   pready
);
   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int WW   = $clog2(MAX_WIDTH + 1);
   localparam int HW   = $clog2(MAX_HEIGHT + 1);
   localparam int CLW  = (WW > 11) ? WW : 11;
   localparam int CLH  = (HW > 11) ? HW : 11;
   localparam int DVW  = (WW > 12) ? WW : 12;
   localparam int TW0  = WW + HW;
   localparam int TW   = (TW0 > POS_W) ? TW0 : POS_W;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_PDIV = 3'd2;
   localparam logic [2:0] S_MAC  = 3'd3;
   localparam logic [2:0] S_SDIV = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   // Configuration registers.
   logic [10:0] frame_width_ff, frame_height_ff;
   logic [23:0] kernel_top_ff, kernel_mid_ff, kernel_bot_ff;
   logic [11:0] divisor_ff;
   logic        border_mode_ff;

   logic [2:0]        state_ff;
   logic [CW-1:0]     col_ff;
   logic [1:0]        row_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [7:0]        win_ff [3][3];
   logic [7:0]        pix_ff;
   logic [TW0-1:0]    total_ff;
   logic              last_ff;
   logic [POS_W-1:0]  y_ff;
   logic [DVW-1:0]    x_ff;
   logic [1:0]        tap_r_ff, tap_c_ff;
   logic signed [19:0] acc_ff;
   logic              neg_ff;
   logic [7:0]        res_ff;

   // Output register.
   logic              out_valid_ff;
   logic [7:0]        out_pix_ff;
   logic              out_last_ff;
   logic              out_load;

   // Shared divider.
   logic [POS_W-1:0]  quo_ff;
   logic [DVW-1:0]    rem_ff, dvs_ff;
   logic [4:0]        dcnt_ff;

   logic [WW-1:0]     w;
   logic [HW-1:0]     h;
   logic [CLW-1:0]    fw_ext;
   logic [CLH-1:0]    fh_ext;
   logic              cfg_wr;
   logic              req_beat, rsp_beat;
   logic [15:0]       ram_rdata;
   logic [DVW:0]      div_shift;
   logic              div_ge;
   logic [1:0]        rr, cc;
   logic [7:0]        tap_pix;
   logic signed [7:0] tap_coef;
   logic [23:0]       krow;
   logic signed [16:0] prod;
   logic              border;
   logic [DVW-1:0]    div_den;
   logic [19:0]       acc_mag;

   assign pready   = 1'b1;
   assign cfg_wr   = psel && penable && pwrite && pready;
   assign req_stall = (state_ff != S_IDLE);
   assign req_beat = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_beat = rsp_valid && !rsp_stall;
   assign rsp_pixel_out = out_pix_ff;
   assign rsp_frame_last = out_last_ff;
   assign out_load = (state_ff == S_OUT) && (!out_valid_ff || !rsp_stall);

   assign fw_ext = CLW'(frame_width_ff);
   assign fh_ext = CLH'(frame_height_ff);
   always_comb begin
      priority if (fw_ext < CLW'(3)) w = WW'(3);
      else if (fw_ext > CLW'(MAX_WIDTH)) w = WW'(MAX_WIDTH);
      else w = WW'(fw_ext);
      priority if (fh_ext < CLH'(3)) h = HW'(3);
      else if (fh_ext > CLH'(MAX_HEIGHT)) h = HW'(MAX_HEIGHT);
      else h = HW'(fh_ext);
   end

   always_comb begin
      unique case (paddr[4:2])
         REG_FRAME_WIDTH:  prdata = CFG_DW'(frame_width_ff);
         REG_FRAME_HEIGHT: prdata = CFG_DW'(frame_height_ff);
         REG_KERNEL_TOP:   prdata = CFG_DW'(kernel_top_ff);
         REG_KERNEL_MID:   prdata = CFG_DW'(kernel_mid_ff);
         REG_KERNEL_BOT:   prdata = CFG_DW'(kernel_bot_ff);
         REG_DIVISOR:      prdata = CFG_DW'(divisor_ff);
         REG_BORDER_MODE:  prdata = CFG_DW'(border_mode_ff);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= RST_FRAME_WIDTH;
         frame_height_ff <= RST_FRAME_HEIGHT;
         kernel_top_ff   <= RST_KERNEL_ROW;
         kernel_mid_ff   <= RST_KERNEL_ROW;
         kernel_bot_ff   <= RST_KERNEL_ROW;
         divisor_ff      <= RST_DIVISOR;
         border_mode_ff  <= 1'b0;
      end else if (cfg_wr) begin
         unique case (paddr[4:2])
            REG_FRAME_WIDTH:  frame_width_ff  <= pwdata[10:0];
            REG_FRAME_HEIGHT: frame_height_ff <= pwdata[10:0];
            REG_KERNEL_TOP:   kernel_top_ff   <= pwdata[23:0];
            REG_KERNEL_MID:   kernel_mid_ff   <= pwdata[23:0];
            REG_KERNEL_BOT:   kernel_bot_ff   <= pwdata[23:0];
            REG_DIVISOR:      divisor_ff      <= pwdata[11:0];
            REG_BORDER_MODE:  border_mode_ff  <= pwdata[0];
            default: ;
         endcase
      end
   end

   // Upper line in the high byte, lower line in the low byte.
   cwf_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_line_ram (
      .clock   (clock),
      .rd_en   (req_beat),
      .wr_en   (state_ff == S_READ),
      .addr    (col_ff),
      .wr_data ({ram_rdata[7:0], pix_ff}),
      .rd_data (ram_rdata)
   );

   assign div_shift = {rem_ff, quo_ff[POS_W-1]};
   assign div_ge    = div_shift >= {1'b0, dvs_ff};
   assign div_den   = (divisor_ff == 12'd0) ? DVW'(1) : DVW'(divisor_ff);
   assign acc_mag   = acc_ff[19] ? 20'(-acc_ff) : 20'(acc_ff);

   // Edge replication folds the outer taps onto the center row or column.
   always_comb begin
      rr = tap_r_ff;
      cc = tap_c_ff;
      if (tap_r_ff == 2'd0 && y_ff == '0) rr = 2'd1;
      if (tap_r_ff == 2'd2 && y_ff >= POS_W'(h - HW'(1))) rr = 2'd1;
      if (tap_c_ff == 2'd0 && x_ff == '0) cc = 2'd1;
      if (tap_c_ff == 2'd2 && x_ff >= DVW'(w - WW'(1))) cc = 2'd1;
      tap_pix = win_ff[rr][cc];
      unique case (tap_r_ff)
         2'd0:    krow = kernel_top_ff;
         2'd1:    krow = kernel_mid_ff;
         default: krow = kernel_bot_ff;
      endcase
      unique case (tap_c_ff)
         2'd0:    tap_coef = krow[7:0];
         2'd1:    tap_coef = krow[15:8];
         default: tap_coef = krow[23:16];
      endcase
      prod = $signed({1'b0, tap_pix}) * tap_coef;
   end

   assign border = (x_ff == '0) || (x_ff >= DVW'(w - WW'(1))) ||
                   (y_ff == '0) || (y_ff >= POS_W'(h - HW'(1)));

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
         out_pix_ff   <= res_ff;
         out_last_ff  <= last_ff;
      end else if (rsp_beat) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         pos_ff   <= '0;
         dcnt_ff  <= '0;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else begin
         if (dcnt_ff != '0) begin
            dcnt_ff <= dcnt_ff - 5'd1;
            quo_ff  <= {quo_ff[POS_W-2:0], div_ge};
            rem_ff  <= div_ge ? DVW'(div_shift - {1'b0, dvs_ff}) : div_shift[DVW-1:0];
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_beat && !(req_kind == KIND_DRAIN && col_ff == '0 && row_ff == '0)) begin
                  pix_ff   <= (req_kind == KIND_DRAIN) ? 8'd0 : req_pixel_in;
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               for (int r = 0; r < 3; r++) begin
                  win_ff[r][0] <= win_ff[r][1];
                  win_ff[r][1] <= win_ff[r][2];
               end
               win_ff[0][2] <= ram_rdata[15:8];
               win_ff[1][2] <= ram_rdata[7:0];
               win_ff[2][2] <= pix_ff;
               if ((CLW + 1)'(col_ff) + (CLW + 1)'(1) >= (CLW + 1)'(w)) begin
                  col_ff <= '0;
                  if (row_ff != 2'd2) row_ff <= row_ff + 2'd1;
               end else begin
                  col_ff <= col_ff + CW'(1);
               end
               total_ff <= TW0'(w) * TW0'(h);
               if (row_ff == 2'd2 || (row_ff == 2'd1 && col_ff != '0)) begin
                  quo_ff   <= pos_ff;
                  rem_ff   <= '0;
                  dvs_ff   <= DVW'(w);
                  dcnt_ff  <= 5'(POS_W);
                  state_ff <= S_PDIV;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_PDIV: begin
               if (dcnt_ff == '0) begin
                  y_ff     <= quo_ff;
                  x_ff     <= rem_ff;
                  last_ff  <= TW'(pos_ff) >= TW'(total_ff - TW0'(1));
                  tap_r_ff <= '0;
                  tap_c_ff <= '0;
                  acc_ff   <= '0;
                  state_ff <= S_MAC;
               end
            end
            S_MAC: begin
               // Border mode 1 keeps the center pixel on border positions.
               if (border_mode_ff && border) begin
                  res_ff   <= win_ff[1][1];
                  state_ff <= S_OUT;
               end else begin
                  acc_ff <= acc_ff + 20'(prod);
                  if (tap_c_ff == 2'd2) begin
                     tap_c_ff <= '0;
                     tap_r_ff <= tap_r_ff + 2'd1;
                  end else begin
                     tap_c_ff <= tap_c_ff + 2'd1;
                  end
                  if (tap_r_ff == 2'd2 && tap_c_ff == 2'd2) begin
                     tap_r_ff <= '0;
                     state_ff <= S_SDIV;
                  end
               end
            end
            S_SDIV: begin
               if (tap_r_ff == '0 && dcnt_ff == '0 && tap_c_ff == '0) begin
                  // First cycle here: load the accumulated magnitude.
                  neg_ff   <= acc_ff[19];
                  quo_ff   <= POS_W'(acc_mag);
                  rem_ff   <= '0;
                  dvs_ff   <= div_den;
                  dcnt_ff  <= 5'(POS_W);
                  tap_c_ff <= 2'd1;
               end else if (dcnt_ff == '0) begin
                  tap_c_ff <= '0;
                  if (neg_ff) res_ff <= 8'd0;
                  else if (quo_ff > POS_W'(PIX_MAX)) res_ff <= PIX_MAX;
                  else res_ff <= quo_ff[7:0];
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               // The result moves to the output register once it is free.
               if (out_load) begin
                  if (last_ff) begin
                     col_ff <= '0;
                     row_ff <= '0;
                     pos_ff <= '0;
                  end else begin
                     pos_ff <= pos_ff + POS_W'(1);
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_rsp_held_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_out) &&
                                 $stable(rsp_frame_last))
      else $error("result beat changed while stalled");
   a_frame_end_clears: assert property (@(posedge clock) disable iff (reset)
      out_load && last_ff |=> col_ff == '0 && row_ff == '0 && pos_ff == '0)
      else $error("counters not cleared at frame end");
   a_div_idle_outside: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_OUT) |-> dcnt_ff == '0)
      else $error("divider running outside a divide state");
   a_ram_write_once: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |=> state_ff != S_READ)
      else $error("line RAM written twice for one beat");
`endif
endmodule
`default_nettype wire

/* bench/tb_conv3x3_window_filter.sv */
// Self-checking testbench for the streaming 3x3 window filter.
`default_nettype none
module tb_conv3x3_window_filter
   import cwf_pkg::*;
();

   localparam int LINE_DEPTH  = DEF_MAX_WIDTH;
   localparam int TAIL_WAIT   = 80;
   localparam int CYCLE_LIMIT = 3000000;

   typedef struct packed {
      logic [7:0] pixel;
      logic       last;
   } filtered_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_kind = KIND_PIXEL;
   logic [7:0]        req_pixel_in = 8'd0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [7:0]        rsp_pixel_out;
   logic              rsp_frame_last;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [CFG_AW-1:0] paddr = '0;
   logic [CFG_DW-1:0] pwdata = '0;
   logic [CFG_DW-1:0] prdata;
   logic              pready;

   conv3x3_window_filter dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_kind(req_kind), .req_pixel_in(req_pixel_in),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_pixel_out(rsp_pixel_out), .rsp_frame_last(rsp_frame_last),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Filter state mirrored by the bench.
   logic [10:0] fw_reg = RST_FRAME_WIDTH;
   logic [10:0] fh_reg = RST_FRAME_HEIGHT;
   logic [23:0] krow_reg [3];
   logic [11:0] div_reg = RST_DIVISOR;
   logic        bmode_reg = 1'b0;
   logic [7:0]  upper_line [LINE_DEPTH];
   logic [7:0]  lower_line [LINE_DEPTH];
   logic [7:0]  win [3][3];
   int unsigned in_col = 0, in_row = 0, out_pos = 0;

   filtered_type pending_pixels[$];
   bit          frame_done = 0;
   int          fail_count = 0;
   int          beats_sent = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   bit          hold_request = 0;
   int          hold_left = 0;
   int unsigned cycle_count = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Receiver: random stalls, plus one long hold-off on request.
   always @(posedge clock) begin
      if (hold_request) begin
         hold_left = 400;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      filtered_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            $error("unexpected result beat: pixel_out %0d frame_last %0b",
                   rsp_pixel_out, rsp_frame_last);
            fail_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_pixel_out !== want.pixel) begin
               $error("pixel_out: expected %0d, actual %0d", want.pixel, rsp_pixel_out);
               fail_count++;
            end
            if (rsp_frame_last !== want.last) begin
               $error("frame_last: expected %0b, actual %0b", want.last, rsp_frame_last);
               fail_count++;
            end
         end
      end
   end

   function automatic int unsigned clamp_dim(logic [10:0] v);
      if (v < 3) return 3;
      if (v > LINE_DEPTH) return LINE_DEPTH;
      return 32'(v);
   endfunction

   function automatic int coef(logic [23:0] r, int i);
      return int'($signed(r[8*i +: 8]));
   endfunction

   // Advances the mirrored filter by one accepted beat.
   task automatic filter_step(input logic kind, input logic [7:0] pix);
      int unsigned w, h, li, col, row, pos, y, x;
      int sum, q, dv, rr, cc;
      logic [7:0] v;
      bit border, last;
      filtered_type res;
      w = clamp_dim(fw_reg);
      h = clamp_dim(fh_reg);
      col = in_col;
      row = in_row;
      v = (kind == KIND_DRAIN) ? 8'd0 : pix;
      li = (col < LINE_DEPTH) ? col : LINE_DEPTH - 1;
      if (kind == KIND_DRAIN && col == 0 && row == 0) return;
      for (int r = 0; r < 3; r++) begin
         win[r][0] = win[r][1];
         win[r][1] = win[r][2];
      end
      win[0][2] = upper_line[li];
      win[1][2] = lower_line[li];
      win[2][2] = v;
      upper_line[li] = lower_line[li];
      lower_line[li] = v;
      if (col + 1 >= w) begin
         in_col = 0;
         in_row = row + 1;
      end else begin
         in_col = col + 1;
      end
      if (!(row >= 2 || (row == 1 && col >= 1))) return;
      pos = out_pos;
      y = pos / w;
      x = pos % w;
      last = pos >= w * h - 1;
      border = x == 0 || x >= w - 1 || y == 0 || y >= h - 1;
      if (bmode_reg && border) begin
         res.pixel = win[1][1];
      end else begin
         sum = 0;
         dv = (div_reg == 0) ? 1 : int'(div_reg);
         for (int r = 0; r < 3; r++) begin
            rr = r;
            if (r == 0 && y == 0) rr = 1;
            if (r == 2 && y >= h - 1) rr = 1;
            for (int c = 0; c < 3; c++) begin
               cc = c;
               if (c == 0 && x == 0) cc = 1;
               if (c == 2 && x >= w - 1) cc = 1;
               sum += int'(win[rr][cc]) * coef(krow_reg[r], c);
            end
         end
         q = sum / dv;
         res.pixel = (q < 0) ? 8'd0 : ((q > 255) ? PIX_MAX : q[7:0]);
      end
      res.last = last;
      pending_pixels.push_back(res);
      if (last) begin
         in_col = 0;
         in_row = 0;
         out_pos = 0;
         frame_done = 1;
      end else begin
         out_pos = (pos + 1) & 20'hFFFFF;
      end
   endtask

   task automatic send_beat(input logic kind, input logic [7:0] pix);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_pixel_in <= pix;
      do @(posedge clock); while (req_stall);
      filter_step(kind, pix);
      beats_sent++;
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_FRAME_WIDTH:  fw_reg = val[10:0];
         REG_FRAME_HEIGHT: fh_reg = val[10:0];
         REG_KERNEL_TOP:   krow_reg[0] = val[23:0];
         REG_KERNEL_MID:   krow_reg[1] = val[23:0];
         REG_KERNEL_BOT:   krow_reg[2] = val[23:0];
         REG_DIVISOR:      div_reg = val[11:0];
         REG_BORDER_MODE:  bmode_reg = val[0];
         default: ;
      endcase
   endtask

   task automatic set_filter(input logic [10:0] w, input logic [10:0] h,
                             input logic [23:0] kt, input logic [23:0] km,
                             input logic [23:0] kb, input logic [11:0] dv,
                             input logic bm);
      csr_write(REG_FRAME_WIDTH, 32'(w));
      csr_write(REG_FRAME_HEIGHT, 32'(h));
      csr_write(REG_KERNEL_TOP, 32'(kt));
      csr_write(REG_KERNEL_MID, 32'(km));
      csr_write(REG_KERNEL_BOT, 32'(kb));
      csr_write(REG_DIVISOR, 32'(dv));
      csr_write(REG_BORDER_MODE, 32'(bm));
   endtask

   // Sender pauses until every result is back and the block has settled.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);
   endtask

   // Sends one frame plus its flush; drains inside and pixels in the tail are noise.
   task automatic send_frame(input int noise_pct);
      int unsigned n, total;
      total = clamp_dim(fw_reg) * clamp_dim(fh_reg);
      n = 0;
      frame_done = 0;
      while (!frame_done) begin
         if (n < total)
            send_beat(($urandom_range(99) < noise_pct) ? KIND_DRAIN : KIND_PIXEL,
                      8'($urandom_range(255)));
         else
            send_beat(($urandom_range(99) < 10) ? KIND_PIXEL : KIND_DRAIN,
                      8'($urandom_range(255)));
         n++;
      end
   endtask

   task automatic test_edge_cases();
      logic [7:0] pix [9] = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255, 8'd128};
      send_idle_pct = 0;
      recv_stall_pct = 0;
      // Saturating kernels on a minimal frame, with a drain at frame start
      // (dropped), one inside the frame and a pixel among the flush beats.
      set_filter(11'd3, 11'd3, 24'hFFFFFF, 24'h7F7F7F, 24'h808080, 12'd1, 1'b0);
      send_beat(KIND_DRAIN, 8'hFF);
      for (int i = 0; i < 9; i++)
         send_beat((i == 4) ? KIND_DRAIN : KIND_PIXEL, pix[i]);
      send_beat(KIND_DRAIN, 8'd0);
      send_beat(KIND_DRAIN, 8'd0);
      send_beat(KIND_PIXEL, 8'd77);
      send_beat(KIND_DRAIN, 8'd0);
      wait_idle();
      // Width and height below range are used as 3; zero divisor acts as one.
      set_filter(11'd0, 11'd0, 24'h000000, 24'h000100, 24'h000000, 12'd0, 1'b1);
      for (int i = 0; i < 9; i++) send_beat(KIND_PIXEL, i[0] ? 8'd255 : 8'd1);
      repeat (4) send_beat(KIND_DRAIN, 8'd0);
      wait_idle();
   endtask

   task automatic random_filter();
      logic [11:0] dv;
      case ($urandom_range(5))
         0: dv = 12'd0;
         1: dv = 12'($urandom_range(4095));
         2: dv = 12'd4095;
         default: dv = 12'($urandom_range(40, 1));
      endcase
      set_filter(11'($urandom_range(8, 0)), 11'($urandom_range(6, 0)),
                 24'($urandom_range(24'hFFFFFF)), 24'($urandom_range(24'hFFFFFF)),
                 24'($urandom_range(24'hFFFFFF)), dv, 1'($urandom_range(1)));
   endtask

   task automatic test_random_stream(input int sp, input int rp, input int items,
                                     input bit long_hold);
      int start;
      send_idle_pct = sp;
      recv_stall_pct = rp;
      start = beats_sent;
      while (beats_sent - start < items) begin
         random_filter();
         if (long_hold) begin
            hold_request = 1;
            long_hold = 0;
         end
         send_frame(5);
         if ($urandom_range(3) == 0) send_beat(KIND_DRAIN, 8'($urandom_range(255)));
         wait_idle();
      end
   endtask

   initial begin
      krow_reg[0] = RST_KERNEL_ROW;
      krow_reg[1] = RST_KERNEL_ROW;
      krow_reg[2] = RST_KERNEL_ROW;
      for (int i = 0; i < LINE_DEPTH; i++) begin
         upper_line[i] = 8'd0;
         lower_line[i] = 8'd0;
      end
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++) win[r][c] = 8'd0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_edge_cases();
      test_random_stream(0, 0, 320, 1'b1);
      test_random_stream(71, 0, 310, 1'b0);
      test_random_stream(0, 71, 310, 1'b0);
      test_random_stream(25, 25, 310, 1'b0);
      wait_idle();
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule
`default_nettype wire

/* filelist.f */
hw/rtl/cwf_pkg.sv
hw/rtl/cwf_ram.sv
hw/rtl/conv3x3_window_filter.sv
bench/tb_conv3x3_window_filter.sv
